[design/hse_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants of the heat stencil Euler step block.
package hse_pkg;

    // Default line buffer depth and row limit.
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    // Field widths.
    localparam int TEMP_W       = 24;
    localparam int ROW_IDX_W    = 12;
    localparam int COL_IDX_W    = 10;
    localparam int GRID_ROWS_W  = 13;
    localparam int GRID_COLS_W  = 11;
    localparam int COEF_W       = 16;
    localparam int CFG_DATA_W   = 16;

    // Register reset values and the smallest usable grid dimension.
    localparam int ROWS_RESET = 64;
    localparam int COLS_RESET = 64;
    localparam int DIM_MIN    = 3;
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd8192;

    // Saturation limits of a Q12.12 temperature.
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7fffff;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh800000;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [ROW_IDX_W-1:0]     t_row_idx;
    typedef logic [COL_IDX_W-1:0]     t_col_idx;
    typedef logic [COEF_W-1:0]        t_coef;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_COEF_ROWS = 2'd2,
        CFG_COEF_COLS = 2'd3
    } t_cfg_idx;

    // Configuration handed to the datapath.
    typedef struct packed {
        t_coef coef_rows;
        t_coef coef_cols;
        logic  restart;
    } t_cfg;

    // Stencil neighbourhood and position flags of one arriving cell.
    typedef struct packed {
        t_temp down;
        t_temp center;
        t_temp up;
        t_temp left;
        t_temp right;
        logic  emit;
        logic  last_row;
        logic  last_col;
        logic  interior;
    } t_window;

    // One result item.
    typedef struct packed {
        t_row_idx row_index;
        t_col_idx col_index;
        t_temp    temperature_out;
        logic     grid_done;
    } t_result;

endpackage

[design/hse_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: cell input, result output and configuration writes.
interface hse_in_if;
    logic          valid;
    logic          ready;
    hse_pkg::t_temp temperature_in;

    modport source (output valid, output temperature_in, input ready);
    modport sink   (input valid, input temperature_in, output ready);
endinterface

interface hse_out_if;
    logic              valid;
    logic              ready;
    hse_pkg::t_row_idx row_index;
    hse_pkg::t_col_idx col_index;
    hse_pkg::t_temp    temperature_out;
    logic              grid_done;

    modport source (output valid, output row_index, output col_index,
                    output temperature_out, output grid_done, input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input temperature_out, input grid_done, output ready);
endinterface

interface hse_cfg_if;
    logic               valid;
    logic               ready;
    hse_pkg::t_cfg_idx  index;
    hse_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/hse_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration registers with grid dimension clamping and restart on a dimension write.
module hse_cfg_regs #(
    parameter int MAX_COLS = hse_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hse_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  hse_pkg::t_cfg_idx              i_index,
    input  hse_pkg::t_cfg_data             i_data,
    output hse_pkg::t_cfg                  o_cfg,
    output logic [$clog2(MAX_ROWS)-1:0]    o_last_row,
    output logic [$clog2(MAX_COLS)-1:0]    o_last_col
);
    localparam int RowW    = $clog2(MAX_ROWS);
    localparam int ColW    = $clog2(MAX_COLS);
    localparam int RowsRst = (hse_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : hse_pkg::ROWS_RESET;
    localparam int ColsRst = (hse_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : hse_pkg::COLS_RESET;

    logic [RowW-1:0]     r_last_row;
    logic [ColW-1:0]     r_last_col;
    hse_pkg::t_coef      r_coef_rows;
    hse_pkg::t_coef      r_coef_cols;
    logic [31:0]         rows_val;
    logic [31:0]         cols_val;
    logic [31:0]         rows_eff;
    logic [31:0]         cols_eff;

    always_comb begin
        rows_val = 32'(i_data[hse_pkg::GRID_ROWS_W-1:0]);
        cols_val = 32'(i_data[hse_pkg::GRID_COLS_W-1:0]);
        if (rows_val < 32'(hse_pkg::DIM_MIN)) begin
            rows_eff = 32'(hse_pkg::DIM_MIN);
        end else if (rows_val > 32'(MAX_ROWS)) begin
            rows_eff = 32'(MAX_ROWS);
        end else begin
            rows_eff = rows_val;
        end
        if (cols_val < 32'(hse_pkg::DIM_MIN)) begin
            cols_eff = 32'(hse_pkg::DIM_MIN);
        end else if (cols_val > 32'(MAX_COLS)) begin
            cols_eff = 32'(MAX_COLS);
        end else begin
            cols_eff = cols_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row  <= RowW'(RowsRst - 1);
            r_last_col  <= ColW'(ColsRst - 1);
            r_coef_rows <= hse_pkg::COEF_RESET;
            r_coef_cols <= hse_pkg::COEF_RESET;
        end else if (i_valid) begin
            case (i_index)
                hse_pkg::CFG_GRID_ROWS: r_last_row  <= RowW'(rows_eff - 32'd1);
                hse_pkg::CFG_GRID_COLS: r_last_col  <= ColW'(cols_eff - 32'd1);
                hse_pkg::CFG_COEF_ROWS: r_coef_rows <= i_data[hse_pkg::COEF_W-1:0];
                hse_pkg::CFG_COEF_COLS: r_coef_cols <= i_data[hse_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready           = 1'b1;
    assign o_last_row        = r_last_row;
    assign o_last_col        = r_last_col;
    assign o_cfg.coef_rows   = r_coef_rows;
    assign o_cfg.coef_cols   = r_coef_cols;
    // A dimension write restarts the grid in the same cycle.
    assign o_cfg.restart     = i_valid && ((i_index == hse_pkg::CFG_GRID_ROWS) ||
                                           (i_index == hse_pkg::CFG_GRID_COLS));
endmodule

[design/hse_line_buf.sv]
`timescale 1ns / 1ps
// Raster counters, the two line buffer memories and the stencil window register.
module hse_line_buf #(
    parameter int MAX_COLS = hse_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hse_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hse_pkg::t_temp               i_temp,
    input  logic [$clog2(MAX_ROWS)-1:0]  i_last_row,
    input  logic [$clog2(MAX_COLS)-1:0]  i_last_col,
    input  logic                         i_restart,
    output logic                         o_s1_valid,
    input  logic                         i_s1_ready,
    output hse_pkg::t_window             o_win,
    output logic [$clog2(MAX_ROWS)-1:0]  o_row,
    output logic [$clog2(MAX_COLS)-1:0]  o_col
);
    localparam int RowW = $clog2(MAX_ROWS);
    localparam int ColW = $clog2(MAX_COLS);

    hse_pkg::t_temp   r_prev_mem  [MAX_COLS];
    hse_pkg::t_temp   r_older_mem [MAX_COLS];
    logic [RowW-1:0]  r_row;
    logic [ColW-1:0]  r_col;
    logic [RowW-1:0]  n_row;
    logic [ColW-1:0]  n_col;
    logic [RowW-1:0]  r_s1_row;
    logic [ColW-1:0]  r_s1_col;
    logic [ColW-1:0]  col_next;
    logic             r_s1_valid;
    logic             n_s1_valid;
    hse_pkg::t_window r_win;
    logic             accept;
    logic             s1_move;
    logic             at_last_row;
    logic             at_last_col;

    assign s1_move     = r_s1_valid && i_s1_ready;
    assign o_ready     = !r_s1_valid || i_s1_ready;
    assign accept      = i_valid && o_ready;
    assign at_last_row = (r_row == i_last_row);
    assign at_last_col = (r_col == i_last_col);
    assign col_next    = r_col + ColW'(1);

    always_comb begin
        n_s1_valid = accept || (r_s1_valid && !i_s1_ready);
        if (at_last_col) begin
            n_col = '0;
            n_row = at_last_row ? '0 : r_row + RowW'(1);
        end else begin
            n_col = col_next;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (i_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // Window capture and line buffer traffic. The older row takes the
    // centre value once the window has moved on, so its write never meets
    // a read of the same column.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win.down     <= i_temp;
            r_win.center   <= r_prev_mem[r_col];
            r_win.right    <= r_prev_mem[col_next];
            r_win.up       <= r_older_mem[r_col];
            r_win.left     <= r_win.center;
            r_win.emit     <= (r_row != '0);
            r_win.last_row <= at_last_row;
            r_win.last_col <= at_last_col;
            r_win.interior <= (r_row > RowW'(1)) && (r_col != '0) && !at_last_col;
            r_s1_row       <= r_row;
            r_s1_col       <= r_col;
            r_prev_mem[r_col] <= i_temp;
        end
        if (s1_move) begin
            r_older_mem[r_s1_col] <= r_win.center;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_win      = r_win;
    assign o_row      = r_s1_row;
    assign o_col      = r_s1_col;
endmodule

[design/hse_stencil_alu.sv]
`timescale 1ns / 1ps
// Stencil update: registered products, shift, sum, saturation and a two-slot result buffer.
module hse_stencil_alu #(
    parameter int MAX_COLS = hse_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hse_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hse_pkg::t_cfg                i_cfg,
    input  logic                         i_s1_valid,
    output logic                         o_s1_ready,
    input  hse_pkg::t_window             i_win,
    input  logic [$clog2(MAX_ROWS)-1:0]  i_row,
    input  logic [$clog2(MAX_COLS)-1:0]  i_col,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hse_pkg::t_result             o_result
);
    localparam int RowW  = $clog2(MAX_ROWS);
    localparam int ColW  = $clog2(MAX_COLS);
    localparam int DiffW = hse_pkg::TEMP_W + 2;
    localparam int ProdW = DiffW + hse_pkg::COEF_W + 1;
    localparam int SumW  = ProdW - 16 + 1;

    logic signed [DiffW-1:0] diff_r;
    logic signed [DiffW-1:0] diff_c;
    logic signed [hse_pkg::COEF_W:0] coef_r;
    logic signed [hse_pkg::COEF_W:0] coef_c;
    logic signed [ProdW-1:0] r_prod_r;
    logic signed [ProdW-1:0] r_prod_c;
    logic signed [SumW-1:0]  sum;
    hse_pkg::t_temp          upd_temp;
    hse_pkg::t_temp          r_center;
    hse_pkg::t_temp          r_down;
    logic                    r_emit;
    logic                    r_last_row;
    logic                    r_last_col;
    logic                    r_interior;
    logic [RowW-1:0]         r_row;
    logic [ColW-1:0]         r_col;
    logic                    r_s2_valid;
    logic [1:0]              nres;
    logic                    s2_move;
    logic                    fire;
    logic [1:0]              r_cnt;
    logic [1:0]              n_cnt;
    logic [1:0]              cnt_pop;
    hse_pkg::t_result        r_slot_a;
    hse_pkg::t_result        r_slot_b;
    hse_pkg::t_result        n_slot_a;
    hse_pkg::t_result        n_slot_b;
    hse_pkg::t_result        res_first;
    hse_pkg::t_result        res_second;

    // Second differences and coefficient products.
    always_comb begin
        diff_r = DiffW'(i_win.up) + DiffW'(i_win.down) - (DiffW'(i_win.center) <<< 1);
        diff_c = DiffW'(i_win.left) + DiffW'(i_win.right) - (DiffW'(i_win.center) <<< 1);
        coef_r = $signed({1'b0, i_cfg.coef_rows});
        coef_c = $signed({1'b0, i_cfg.coef_cols});
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_valid && o_s1_ready) begin
            r_prod_r   <= ProdW'(coef_r) * ProdW'(diff_r);
            r_prod_c   <= ProdW'(coef_c) * ProdW'(diff_c);
            r_center   <= i_win.center;
            r_down     <= i_win.down;
            r_emit     <= i_win.emit;
            r_last_row <= i_win.last_row;
            r_last_col <= i_win.last_col;
            r_interior <= i_win.interior;
            r_row      <= i_row;
            r_col      <= i_col;
        end
    end

    // Floor shift of each product, then sum and clip to the Q12.12 range.
    always_comb begin
        sum = SumW'(r_center) + SumW'(r_prod_r >>> 16) + SumW'(r_prod_c >>> 16);
        if (sum > SumW'(hse_pkg::TEMP_MAX)) begin
            upd_temp = hse_pkg::TEMP_MAX;
        end else if (sum < SumW'(hse_pkg::TEMP_MIN)) begin
            upd_temp = hse_pkg::TEMP_MIN;
        end else begin
            upd_temp = hse_pkg::TEMP_W'(sum);
        end

        res_first.row_index       = hse_pkg::ROW_IDX_W'(r_row - RowW'(1));
        res_first.col_index       = hse_pkg::COL_IDX_W'(r_col);
        res_first.temperature_out = r_interior ? upd_temp : r_center;
        res_first.grid_done       = 1'b0;
        res_second.row_index       = hse_pkg::ROW_IDX_W'(r_row);
        res_second.col_index       = hse_pkg::COL_IDX_W'(r_col);
        res_second.temperature_out = r_down;
        res_second.grid_done       = r_last_col;
    end

    // Result buffer: slot A is shown on the port, slot B queues the result behind it: the second
    // result of a last-row cell, or a result that arrives while slot A waits.
    always_comb begin
        nres     = !r_emit ? 2'd0 : (r_last_row ? 2'd2 : 2'd1);
        fire     = (r_cnt != 2'd0) && i_ready;
        cnt_pop  = r_cnt - {1'b0, fire};
        s2_move  = r_s2_valid && (nres <= (2'd2 - cnt_pop));
        n_slot_a = r_slot_a;
        n_slot_b = r_slot_b;
        if (fire && (r_cnt == 2'd2)) begin
            n_slot_a = r_slot_b;
        end
        if (s2_move && (nres != 2'd0)) begin
            if (cnt_pop == 2'd0) begin
                n_slot_a = res_first;
                n_slot_b = res_second;
            end else begin
                n_slot_b = res_first;
            end
        end
        n_cnt = cnt_pop + (s2_move ? nres : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 2'd0;
            r_s2_valid <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_s2_valid <= (i_s1_valid && o_s1_ready) || (r_s2_valid && !s2_move);
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_a <= n_slot_a;
        r_slot_b <= n_slot_b;
    end

    assign o_s1_ready = !r_s2_valid || s2_move;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_result   = r_slot_a;
endmodule

[design/heat_stencil_euler_step.sv]
`timescale 1ns / 1ps
// Top level of the heat stencil Euler step block: configuration, line buffers and update.
// A cell's first result passes the window, product and result buffer registers before it
// is shown. Throughput: one cell per cycle while the output takes results; a last-row cell
// gives two results, so the output sets the pace there. First-row cells give no result.
// Reset (synchronous, active low) clears counters, pipeline and result buffer and loads the
// default grid and coefficients; line buffer contents are undefined until written.
module heat_stencil_euler_step #(
    parameter int MAX_COLS = hse_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hse_pkg::MAX_ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hse_cfg_if.sink   i_cfg,
    hse_in_if.sink    i_in,
    hse_out_if.source o_out
);
    localparam int RowW = $clog2(MAX_ROWS);
    localparam int ColW = $clog2(MAX_COLS);

    hse_pkg::t_cfg    cfg;
    logic [RowW-1:0]  last_row;
    logic [ColW-1:0]  last_col;
    logic             s1_valid;
    logic             s1_ready;
    hse_pkg::t_window win;
    logic [RowW-1:0]  s1_row;
    logic [ColW-1:0]  s1_col;
    hse_pkg::t_result result;

    // Configuration: every write transfer is taken at once. Grid dimensions
    // are clamped to the supported range and stored as last-index values;
    // writing either dimension sends the raster position back to the origin.
    hse_cfg_regs #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cfg.valid),
        .o_ready    (i_cfg.ready),
        .i_index    (i_cfg.index),
        .i_data     (i_cfg.data),
        .o_cfg      (cfg),
        .o_last_row (last_row),
        .o_last_col (last_col)
    );

    // Line buffers: on each cell transfer the previous row is read at the
    // column and the column to its right, the older row at the column, and
    // the arriving cell replaces the previous row entry. The left neighbour
    // is the centre of the cell before, kept in the window register.
    hse_line_buf #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_temp     (i_in.temperature_in),
        .i_last_row (last_row),
        .i_last_col (last_col),
        .i_restart  (cfg.restart),
        .o_s1_valid (s1_valid),
        .i_s1_ready (s1_ready),
        .o_win      (win),
        .o_row      (s1_row),
        .o_col      (s1_col)
    );

    // Update: the two weighted second differences are multiplied into
    // registers, then shifted with rounding toward minus infinity, summed
    // with the centre and saturated. Border cells keep their value. The
    // two-slot result buffer lets the pipeline keep moving while a result
    // waits for its transfer, and holds both results of a last-row cell.
    hse_stencil_alu #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_stencil_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (s1_valid),
        .o_s1_ready (s1_ready),
        .i_win      (win),
        .i_row      (s1_row),
        .i_col      (s1_col),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (result)
    );

    assign o_out.row_index       = result.row_index;
    assign o_out.col_index       = result.col_index;
    assign o_out.temperature_out = result.temperature_out;
    assign o_out.grid_done       = result.grid_done;
endmodule

[design/hse_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the heat stencil Euler step block and its bind statement.
module hse_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input hse_pkg::t_row_idx i_row_index,
    input hse_pkg::t_col_idx i_col_index,
    input hse_pkg::t_temp    i_temperature_out,
    input logic              i_grid_done
);
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_row_index) && $stable(i_col_index)
            && $stable(i_temperature_out) && $stable(i_grid_done))
        else $error("stalled result changed");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with the result buffer empty");

    a_done_in_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_grid_done |-> (i_row_index != '0) && (i_col_index != '0))
        else $error("grid end flagged outside the last corner");
endmodule

bind heat_stencil_euler_step hse_checker u_hse_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_row_index       (o_out.row_index),
    .i_col_index       (o_out.col_index),
    .i_temperature_out (o_out.temperature_out),
    .i_grid_done       (o_out.grid_done)
);

[tb/heat_stencil_euler_step_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the heat stencil Euler step block, driven over its three channels.
module heat_stencil_euler_step_tb;

    import hse_pkg::*;

    // Run shape. The random part counts cells, not results.
    localparam int unsigned RANDOM_CELLS  = 600;
    localparam int unsigned TALL_CELLS    = 192;
    localparam int unsigned WIDE_CELLS    = MAX_COLS_DEF + 64;
    localparam int unsigned HOLD_CYCLES   = 500;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned MAX_SHOWN     = 10;
    localparam longint     TIMEOUT_NS    = 4_000_000;

    // Kinds of row in the directed script.
    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_WRITE = 1'b1
    } t_script_op;

    // One directed row. A cell row with typed set carries the hand-worked temperatures of
    // the results it releases; the coordinates and the done flag still come from the
    // stencil model. The register field is ignored on cell rows.
    typedef struct packed {
        t_script_op op;
        t_cfg_idx   reg_idx;
        t_temp      value;
        logic       typed;
        t_temp      first_temp;
        t_temp      second_temp;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hse_cfg_if cfg_ch ();
    hse_in_if  in_ch ();
    hse_out_if out_ch ();

    heat_stencil_euler_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------------------
    // Stencil model: its own copy of the registers, the two line stores and the position of
    // the next arriving cell, all at their reset values.
    // ------------------------------------------------------------------------------------
    logic [GRID_ROWS_W-1:0] set_rows = GRID_ROWS_W'(ROWS_RESET);
    logic [GRID_COLS_W-1:0] set_cols = GRID_COLS_W'(COLS_RESET);
    t_coef                  k_rows   = COEF_RESET;
    t_coef                  k_cols   = COEF_RESET;
    int unsigned            cur_row  = 0;
    int unsigned            cur_col  = 0;

    // line_above holds the row two above the arriving cell, line_recent the row just above.
    t_temp line_above  [MAX_COLS_DEF] = '{default: '0};
    t_temp line_recent [MAX_COLS_DEF] = '{default: '0};

    // Results released by the latest cell, and the updated cells still owed by the block.
    t_result fresh [2];
    t_result due_updates [$];

    int unsigned faults = 0;
    bit          calm    = 1'b0;
    bit          hold_go = 1'b0;

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
        return (v < DIM_MIN) ? DIM_MIN : ((v > hi) ? hi : v);
    endfunction

    // Takes the arriving cell (the lower neighbour of the cell one row up), fills fresh with
    // the cells it releases and returns how many there are.
    function automatic int advance_stencil(input t_temp down);
        int unsigned rows, cols, i, j;
        bit          last_row, last_col;
        longint      centre, acc, dr, dc;
        int          n;
        rows     = eff_dim(set_rows, MAX_ROWS_DEF);
        cols     = eff_dim(set_cols, MAX_COLS_DEF);
        i        = cur_row;
        j        = cur_col;
        last_row = (i + 1 >= rows);
        last_col = (j + 1 >= cols);
        n        = 0;
        if (i >= rows) i = rows - 1;
        if (j >= cols) j = cols - 1;

        if (i >= 1) begin
            centre = line_recent[j];
            acc    = centre;
            // Only interior cells diffuse; the border keeps its temperature.
            if (i >= 2 && j >= 1 && j + 1 < cols) begin
                dr  = longint'(line_above[j]) + longint'(down) - 2 * centre;
                dc  = longint'(line_above[j - 1]) + longint'(line_recent[j + 1]) - 2 * centre;
                // Arithmetic shifts floor, exactly as the hardware truncates its products.
                acc = centre + ((longint'(k_rows) * dr) >>> 16)
                             + ((longint'(k_cols) * dc) >>> 16);
                if (acc > longint'(TEMP_MAX)) acc = longint'(TEMP_MAX);
                if (acc < longint'(TEMP_MIN)) acc = longint'(TEMP_MIN);
            end
            fresh[0].row_index       = t_row_idx'(i - 1);
            fresh[0].col_index       = t_col_idx'(j);
            fresh[0].temperature_out = t_temp'(acc);
            fresh[0].grid_done       = 1'b0;
            n = 1;
            // On the last row the arriving cell is itself on the border and leaves as it is.
            if (last_row) begin
                fresh[1].row_index       = t_row_idx'(i);
                fresh[1].col_index       = t_col_idx'(j);
                fresh[1].temperature_out = down;
                fresh[1].grid_done       = last_col;
                n = 2;
            end
        end

        line_above[j]  = line_recent[j];
        line_recent[j] = down;

        if (last_col) begin
            cur_col = 0;
            cur_row = last_row ? 0 : i + 1;
        end else begin
            cur_col = j + 1;
            cur_row = i;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------------------------
    // Channel drivers. Every task starts and ends just after a rising edge, and inputs only
    // change by nonblocking assignment there. A cell that has been transferred leaves valid
    // high, so that the next cell can follow without a bubble; whoever stops sending must
    // therefore lower it, which drain does.
    // ------------------------------------------------------------------------------------
    task automatic feed_cell(input t_temp t, input bit typed, input t_temp hand_first,
                             input t_temp hand_second);
        int n;
        if (!calm && $urandom_range(99) < 5) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 50);
        end
        in_ch.valid          <= 1'b1;
        in_ch.temperature_in <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        n = advance_stencil(t);
        for (int k = 0; k < n; k++) begin
            if (typed) fresh[k].temperature_out = (k == 0) ? hand_first : hand_second;
            due_updates.push_back(fresh[k]);
        end
    endtask

    // Register writes happen only with the block idle. Valid drops for one cycle after
    // each transfer so that back-to-back writes never raise it in the step that lowers it.
    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        t_cfg_data d;
        d = t_cfg_data'(value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_GRID_ROWS: begin
                set_rows = d[GRID_ROWS_W-1:0];
                cur_row  = 0;
                cur_col  = 0;
            end
            CFG_GRID_COLS: begin
                set_cols = d[GRID_COLS_W-1:0];
                cur_row  = 0;
                cur_col  = 0;
            end
            CFG_COEF_ROWS: k_rows = d[COEF_W-1:0];
            CFG_COEF_COLS: k_cols = d[COEF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stops offering cells and waits until every owed result has been transferred.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (due_updates.size() != 0);
    endtask

    // A first-row cell releases nothing, so the block may still be busy with one when the
    // queue runs dry; settle lets it leave the window and product registers before a register write.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_temp random_temp(input t_temp base);
        case ($urandom_range(9))
            0:       return TEMP_MAX;
            1:       return TEMP_MIN;
            2, 3:    return t_temp'($urandom);
            // A smooth field around the grid's base keeps most interior updates unsaturated.
            default: return base + t_temp'($urandom_range(0, 8191)) - t_temp'(4096);
        endcase
    endfunction

    function automatic int unsigned random_coef();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 16'hffff;
            2:       return $urandom_range(0, 255);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Directed script. Two 3x3 grids at full coefficient strength, entered through
    // dimension writes below the minimum so that both clamp to three. The first has a
    // frozen centre in a ring of hot neighbours and must saturate high; the second is the
    // mirror image and must saturate low. Every other cell is on the border and comes back
    // unchanged, first-row cells release nothing, and last-row cells release two results.
    // ------------------------------------------------------------------------------------
    t_script_row script [24] = '{
        '{OP_WRITE, CFG_GRID_ROWS, 24'sd0,     1'b0, 24'sd0,    24'sd0},
        '{OP_WRITE, CFG_GRID_COLS, 24'sd2,     1'b0, 24'sd0,    24'sd0},
        '{OP_WRITE, CFG_COEF_ROWS, 24'sd65535, 1'b0, 24'sd0,    24'sd0},
        '{OP_WRITE, CFG_COEF_COLS, 24'sd65535, 1'b0, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, 24'sd7,     1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MAX,   1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, -24'sd5,    1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MAX,   1'b1, 24'sd7,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MIN,   1'b1, TEMP_MAX,  24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MAX,   1'b1, -24'sd5,   24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, -24'sd1,    1'b1, TEMP_MAX,  -24'sd1},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MAX,   1'b1, TEMP_MAX,  TEMP_MAX},
        '{OP_CELL,  CFG_GRID_ROWS, 24'sd1,     1'b1, TEMP_MAX,  24'sd1},
        '{OP_WRITE, CFG_GRID_ROWS, 24'sd2,     1'b0, 24'sd0,    24'sd0},
        '{OP_WRITE, CFG_GRID_COLS, 24'sd1,     1'b0, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, 24'sd0,     1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MIN,   1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, 24'sd0,     1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MIN,   1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MAX,   1'b1, TEMP_MIN,  24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MIN,   1'b1, 24'sd0,    24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, 24'sd0,     1'b1, TEMP_MIN,  24'sd0},
        '{OP_CELL,  CFG_GRID_ROWS, TEMP_MIN,   1'b1, TEMP_MIN,  TEMP_MIN},
        '{OP_CELL,  CFG_GRID_ROWS, 24'sd0,     1'b1, TEMP_MIN,  24'sd0}
    };

    // ------------------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------------------
    initial begin : stimulus
        t_temp       base;
        int unsigned rows_pick, cols_pick, span, random_cells;

        in_ch.valid          <= 1'b0;
        in_ch.temperature_in <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_GRID_ROWS;
        cfg_ch.data          <= '0;
        i_rst_n              <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset, with no write at all: two full rows of the default width
        // and the start of a third, so the default width decides where the rows wrap and
        // the default coefficients decide the first interior updates.
        base = t_temp'($urandom);
        repeat (2 * COLS_RESET + 2) feed_cell(random_temp(base), 1'b0, '0, '0);

        // The directed script restarts the grid part-way through, which its first
        // dimension write does by design.
        foreach (script[k]) begin
            if (script[k].op == OP_WRITE) begin
                settle();
                write_reg(script[k].reg_idx, script[k].value[CFG_DATA_W-1:0]);
            end else begin
                feed_cell(script[k].value, script[k].typed, script[k].first_temp,
                          script[k].second_temp);
            end
        end

        // Tallest grid: the row count is written above the limit and clamps to the full
        // depth. Three columns keep the rows short; only the first rows are sent before
        // the next dimension write restarts the grid. Neither side idles here.
        settle();
        write_reg(CFG_GRID_ROWS, 8191);
        write_reg(CFG_GRID_COLS, 3);
        write_reg(CFG_COEF_ROWS, random_coef());
        write_reg(CFG_COEF_COLS, random_coef());
        calm = 1'b1;
        base = t_temp'($urandom);
        repeat (TALL_CELLS) feed_cell(random_temp(base), 1'b0, '0, '0);
        settle();
        calm = 1'b0;

        // Widest grid: the column count clamps to the full line store width. One full row
        // and the start of the next show the column index wrapping at the store width.
        write_reg(CFG_GRID_ROWS, 3);
        write_reg(CFG_GRID_COLS, 2047);
        write_reg(CFG_COEF_ROWS, random_coef());
        write_reg(CFG_COEF_COLS, random_coef());
        base = t_temp'($urandom);
        repeat (WIDE_CELLS) feed_cell(random_temp(base), 1'b0, '0, '0);

        // Random small grids. Most run to completion; now and then one is cut short and
        // the next dimension write restarts it, and now and then the sender waits for the
        // block to empty in the middle of a grid.
        random_cells = 0;
        while (random_cells < RANDOM_CELLS) begin
            settle();
            rows_pick = ($urandom_range(15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            cols_pick = ($urandom_range(15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 30);
            write_reg(CFG_GRID_ROWS, rows_pick);
            write_reg(CFG_GRID_COLS, cols_pick);
            if ($urandom_range(2) != 0) write_reg(CFG_COEF_ROWS, random_coef());
            if ($urandom_range(2) != 0) write_reg(CFG_COEF_COLS, random_coef());
            span = eff_dim(rows_pick, MAX_ROWS_DEF) * eff_dim(cols_pick, MAX_COLS_DEF);
            if ($urandom_range(15) == 0) span = $urandom_range(1, span - 1);
            // The receiver's long hold-off starts with the first random grid, so the
            // block backs up and must refuse cells until the results drain.
            if (random_cells == 0) hold_go = 1'b1;
            base = t_temp'($urandom);
            repeat (span) begin
                if ($urandom_range(299) == 0) drain();
                feed_cell(random_temp(base), 1'b0, '0, '0);
                random_cells++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Result receiver: idles at random except while the grids run calm, and once holds
    // ready low for a long stretch, counted here in cycles.
    // ------------------------------------------------------------------------------------
    initial begin : receiver
        int unsigned stall_left;
        bit          held;
        stall_left = 0;
        held       = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Scoreboard: each transferred result is checked against the oldest owed update.
    // Values read here are those from before the edge, as all drivers use nonblocking
    // assignments.
    // ------------------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.row_index       = out_ch.row_index;
            got.col_index       = out_ch.col_index;
            got.temperature_out = out_ch.temperature_out;
            got.grid_done       = out_ch.grid_done;
            if (due_updates.size() == 0) begin
                faults++;
                if (faults <= MAX_SHOWN)
                    $display("%0t: result with none owed: row %0d col %0d temp %0d done %0b",
                             $realtime, got.row_index, got.col_index, got.temperature_out,
                             got.grid_done);
            end else begin
                want = due_updates.pop_front();
                if (got.row_index !== want.row_index || got.col_index !== want.col_index ||
                    got.temperature_out !== want.temperature_out ||
                    got.grid_done !== want.grid_done) begin
                    faults++;
                    if (faults <= MAX_SHOWN)
                        $display({"%0t: cell differs: expected row %0d col %0d temp %0d ",
                                  "done %0b, got row %0d col %0d temp %0d done %0b"},
                                 $realtime, want.row_index, want.col_index,
                                 want.temperature_out, want.grid_done, got.row_index,
                                 got.col_index, got.temperature_out, got.grid_done);
                end
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/hse_pkg.sv
design/hse_ifs.sv
design/hse_cfg_regs.sv
design/hse_line_buf.sv
design/hse_stencil_alu.sv
design/heat_stencil_euler_step.sv
design/hse_checker.sv
tb/heat_stencil_euler_step_tb.sv
